/* sv/pmq_pkg.sv */
// ----------------------------------------------------------------------------
// pmq_pkg
// Shared types and codes for the priority message queue.
// ----------------------------------------------------------------------------
package pmq_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;

  localparam logic [1:0] PRIO_LOW    = 2'd0;
  localparam logic [1:0] PRIO_URGENT = 2'd3;

  typedef enum logic [2:0] {
    FN_SEND     = 3'd0,
    FN_RECV_BST = 3'd1,
    FN_RECV_TYP = 3'd2,
    FN_HAS_TYP  = 3'd3,
    FN_FLUSH    = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_PRESENT = 2'd3
  } status_t;

  typedef struct packed {
    logic [15:0] sender;
    logic [2:0]  kind;
    logic [1:0]  urg;
    logic [15:0] len;
    logic [63:0] payload;
    logic [31:0] tick;
    logic [31:0] seq;
  } entry_t;

endpackage

/* sv/pmq_mem.sv */
// ----------------------------------------------------------------------------
// pmq_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pmq_mem #(
  parameter int DEPTH = pmq_pkg::DEF_QUEUE_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  pmq_pkg::entry_t wdata,
  input  logic [AW-1:0]   raddr,
  output pmq_pkg::entry_t rdata
);
  import pmq_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* sv/priority_message_queue.sv */
// ----------------------------------------------------------------------------
// priority_message_queue
// Bounded ring of prioritized messages with drop-lowest replacement.
// ----------------------------------------------------------------------------
// One request is worked at a time; in_ready is high only when the sequencer
// is idle. A send with room, a flush, a low-priority send to a full ring,
// unused codes and requests on an empty ring go from idle straight to the
// finish state. A scan visits each entry with a read state, then an evaluate
// state, through the single read port of the entry memory; a receive then
// shifts entries to close the gap, each with a read and a write state. The
// worst case is a receive-best that picks the newest entry of a full ring.
// The result sits in an output register, so the next request is taken while
// the previous result waits for out_ready.
// ----------------------------------------------------------------------------
module priority_message_queue #(
  parameter int QUEUE_DEPTH = pmq_pkg::DEF_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [15:0] in_sender_id,
  input  logic [2:0]  in_kind,
  input  logic [1:0]  in_urgency,
  input  logic [15:0] in_length,
  input  logic [63:0] in_payload_word,
  input  logic [31:0] in_now_ticks,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [15:0] out_sender,
  output logic [2:0]  out_kind,
  output logic [1:0]  out_urgency,
  output logic [15:0] out_length,
  output logic [63:0] out_payload,
  output logic [31:0] out_stamp,
  output logic [31:0] out_sequence,
  output logic [4:0]  out_occupancy,
  output logic        out_replaced
);
  import pmq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_EV, S_SHRD, S_SHWR, S_FIN
  } state_t;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0]   fill_r, fill_nxt, idx_r, idx_nxt;
  logic [31:0]     drops_r, drops_nxt, seq_r, seq_nxt;
  logic [2:0]      func_r, func_nxt;
  entry_t          new_r, new_nxt;     // entry carried by a send
  entry_t          best_r, best_nxt;   // candidate / entry to return
  logic [AW-1:0]   slot_r, slot_nxt;   // slot of the entry being evaluated
  logic [AW-1:0]   pick_r, pick_nxt;   // chosen slot (drop or receive)
  logic [AW-1:0]   shi_r, shi_nxt;     // shift cursor
  logic [1:0]      low_r, low_nxt;
  logic            found_r, found_nxt;
  logic            emit_r, emit_nxt, rep_r, rep_nxt;
  status_t         st_r, st_nxt;

  logic            ov_r, ov_nxt;
  entry_t          oe_r, oe_nxt;
  status_t         ost_r, ost_nxt;
  logic [4:0]      occ_r, occ_nxt;
  logic            orep_r, orep_nxt;

  logic            mem_we;
  logic [AW-1:0]   mem_wa, mem_ra;
  entry_t          mem_wd, rdata;

  pmq_mem #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_wa),
    .wdata (mem_wd),
    .raddr (mem_ra),
    .rdata (rdata)
  );

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
    return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] p);
    return (p == '0) ? AW'(QUEUE_DEPTH - 1) : p - AW'(1);
  endfunction

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] h,
                                            input logic [CW-1:0] off);
    logic [AW:0] s;
    s = (AW+1)'(h) + (AW+1)'(off);
    if (s >= (AW+1)'(QUEUE_DEPTH)) s = s - (AW+1)'(QUEUE_DEPTH);
    return s[AW-1:0];
  endfunction

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    logic        last;
    logic [1:0]  lw;
    logic [AW-1:0] dp;
    logic [8:0]  fe;
    state_nxt = state_r;
    head_nxt  = head_r;  tail_nxt = tail_r;  fill_nxt = fill_r;
    idx_nxt   = idx_r;   drops_nxt = drops_r; seq_nxt = seq_r;
    func_nxt  = func_r;  new_nxt = new_r;    best_nxt = best_r;
    slot_nxt  = slot_r;  pick_nxt = pick_r;  shi_nxt = shi_r;
    low_nxt   = low_r;   found_nxt = found_r;
    emit_nxt  = emit_r;  rep_nxt = rep_r;    st_nxt = st_r;
    ov_nxt    = ov_r;    oe_nxt = oe_r;      ost_nxt = ost_r;
    occ_nxt   = occ_r;   orep_nxt = orep_r;
    mem_we = 1'b0; mem_wa = tail_r; mem_wd = new_r; mem_ra = slot_of(head_r, idx_r);
    last = ((idx_r + CW'(1)) == fill_r);
    lw = low_r; dp = pick_r;
    fe = 9'(fill_r);

    if (ov_r && out_ready) ov_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt = in_func;
          new_nxt  = '{sender: in_sender_id, kind: in_kind, urg: in_urgency,
                       len: in_length, payload: in_payload_word,
                       tick: in_now_ticks, seq: seq_r};
          emit_nxt = 1'b0; rep_nxt = 1'b0; found_nxt = 1'b0;
          idx_nxt = '0; low_nxt = PRIO_URGENT; pick_nxt = head_r;
          state_nxt = S_FIN;
          case (in_func)
            FN_SEND: begin
              if (fill_r < CW'(QUEUE_DEPTH)) begin
                mem_we = 1'b1; mem_wa = tail_r;
                mem_wd = '{sender: in_sender_id, kind: in_kind, urg: in_urgency,
                           len: in_length, payload: in_payload_word,
                           tick: in_now_ticks, seq: seq_r};
                tail_nxt = ring_next(tail_r);
                fill_nxt = fill_r + CW'(1);
                seq_nxt = seq_r + 32'd1;
                st_nxt = ST_OK;
              end else if (in_urgency > PRIO_LOW) begin
                state_nxt = S_RD;
              end else begin
                st_nxt = ST_FULL;
              end
            end
            FN_RECV_BST, FN_RECV_TYP, FN_HAS_TYP: begin
              if (fill_r == '0) st_nxt = ST_EMPTY;
              else state_nxt = S_RD;
            end
            FN_FLUSH: begin
              head_nxt = '0; tail_nxt = '0; fill_nxt = '0;
              st_nxt = ST_OK;
            end
            default: st_nxt = ST_EMPTY;
          endcase
        end
      end
      S_RD: begin
        mem_ra = slot_of(head_r, idx_r);
        slot_nxt = slot_of(head_r, idx_r);
        state_nxt = S_EV;
      end
      S_EV: begin
        idx_nxt = idx_r + CW'(1);
        state_nxt = S_RD;
        case (func_r)
          FN_SEND: begin
            if (rdata.urg < low_r) begin
              lw = rdata.urg; dp = slot_r;
            end
            low_nxt = lw; pick_nxt = dp;
            if (last) begin
              state_nxt = S_FIN;
              if (new_r.urg > lw) begin
                mem_we = 1'b1; mem_wa = dp;
                mem_wd = new_r; mem_wd.seq = seq_r;
                seq_nxt = seq_r + 32'd1;
                drops_nxt = drops_r + 32'd1;
                rep_nxt = 1'b1;
                st_nxt = ST_OK;
              end else begin
                st_nxt = ST_FULL;
              end
            end
          end
          FN_RECV_BST: begin
            dp = pick_r;
            if (!found_r || rdata.urg > best_r.urg ||
                (rdata.urg == best_r.urg && rdata.tick < best_r.tick)) begin
              best_nxt = rdata; dp = slot_r;
            end
            found_nxt = 1'b1; pick_nxt = dp;
            if (last) begin
              emit_nxt = 1'b1; st_nxt = ST_OK;
              shi_nxt = dp; state_nxt = S_SHRD;
            end
          end
          default: begin
            if (rdata.kind == new_r.kind) begin
              if (func_r == FN_RECV_TYP) begin
                best_nxt = rdata; emit_nxt = 1'b1; st_nxt = ST_OK;
                shi_nxt = slot_r; state_nxt = S_SHRD;
              end else begin
                st_nxt = ST_PRESENT; state_nxt = S_FIN;
              end
            end else if (last) begin
              st_nxt = ST_EMPTY; state_nxt = S_FIN;
            end
          end
        endcase
      end
      S_SHRD: begin
        mem_ra = ring_prev(shi_r);
        if (shi_r == head_r) begin
          head_nxt = ring_next(head_r);
          fill_nxt = fill_r - CW'(1);
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_SHWR;
        end
      end
      S_SHWR: begin
        mem_we = 1'b1; mem_wa = shi_r; mem_wd = rdata;
        shi_nxt = ring_prev(shi_r);
        state_nxt = S_SHRD;
      end
      S_FIN: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          oe_nxt = emit_r ? best_r : '0;
          ost_nxt = st_r;
          occ_nxt = fe[4:0];
          orep_nxt = rep_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      fill_r  <= '0;
      drops_r <= '0;
      seq_r   <= 32'd1;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      fill_r  <= fill_nxt;
      drops_r <= drops_nxt;
      seq_r   <= seq_nxt;
      ov_r    <= ov_nxt;
    end
    idx_r   <= idx_nxt;
    func_r  <= func_nxt;
    new_r   <= new_nxt;
    best_r  <= best_nxt;
    slot_r  <= slot_nxt;
    pick_r  <= pick_nxt;
    shi_r   <= shi_nxt;
    low_r   <= low_nxt;
    found_r <= found_nxt;
    emit_r  <= emit_nxt;
    rep_r   <= rep_nxt;
    st_r    <= st_nxt;
    oe_r    <= oe_nxt;
    ost_r   <= ost_nxt;
    occ_r   <= occ_nxt;
    orep_r  <= orep_nxt;
  end

  assign out_valid     = ov_r;
  assign out_status    = ost_r;
  assign out_sender    = oe_r.sender;
  assign out_kind      = oe_r.kind;
  assign out_urgency   = oe_r.urg;
  assign out_length    = oe_r.len;
  assign out_payload   = oe_r.payload;
  assign out_stamp     = oe_r.tick;
  assign out_sequence  = oe_r.seq;
  assign out_occupancy = occ_r;
  assign out_replaced  = orep_r;

endmodule

/* sv/pmq_checker.sv */
// ----------------------------------------------------------------------------
// pmq_checker
// Port-level checks for the priority message queue, bound to the top level.
// ----------------------------------------------------------------------------
module pmq_checker #(
  parameter int QUEUE_DEPTH = pmq_pkg::DEF_QUEUE_DEPTH
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [31:0] out_stamp,
  input logic [31:0] out_sequence,
  input logic [4:0]  out_occupancy,
  input logic        out_replaced
);
  import pmq_pkg::*;

  localparam logic [8:0] DEPTH9 = 9'(QUEUE_DEPTH);

  // one request in flight: input closes right after an accept
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in progress");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result changed while stalled");

  a_rep_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_replaced |-> out_status == ST_OK)
    else $error("replacement without success");

  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_occupancy == DEPTH9[4:0])
    else $error("refused send while ring not full");

  a_nomsg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_stamp == 32'd0 && out_sequence == 32'd0)
    else $error("message fields set without a receive");

endmodule

bind priority_message_queue pmq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_pmq_checker (.*);
